// ===== sv/dcsl_pkg.sv =====
// ----------------------------------------------------------------------------
// dcsl_pkg
// Shared types, constants and helpers of the dual-core slot time latch.
// ----------------------------------------------------------------------------
`default_nettype none
package dcsl_pkg;

    localparam int CORE_W = 171;
    localparam int IN_W   = 344;
    localparam int OUT_W  = 48;

    localparam logic [19:0] MHZ_SCALE = 20'd1000000;
    localparam logic [31:0] DELTA_LIM = 32'h7FFF_FFFF;
    localparam logic [63:0] U64_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] REG_TICK_RATE = 2'd0;
    localparam logic [1:0] REG_HALF_SLOT = 2'd1;
    localparam logic [1:0] REG_CNT_MASK  = 2'd2;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_TOTAL,
        OP_SUM,
        OP_DIV_CYC,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV_FRAC,
        OP_CORE_END,
        OP_DIV_SLOT,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic core;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_valid;
    } t_sts;

    typedef struct packed {
        logic [26:0] tick_rate;
        logic [15:0] half_slot;
        logic [31:0] mask;
    } t_cfg;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? U64_MAX : s[63:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/dcsl_div.sv =====
// ----------------------------------------------------------------------------
// dcsl_div
// Shared radix-2 restoring divider, 64-bit dividend by 30-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dcsl_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [29:0] i_divisor,
    output logic             o_busy,
    output logic [63:0]      o_quot,
    output logic [29:0]      o_rem
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [29:0] r_rem;
    logic [29:0] r_div;
    logic [30:0] w_sh;
    logic [31:0] w_diff;

    assign w_sh   = {r_rem, r_q[63]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (w_diff[31]) begin
                r_rem <= w_sh[29:0];
            end else begin
                r_rem <= w_diff[29:0];
            end
            r_q   <= {r_q[62:0], ~w_diff[31]};
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== sv/dcsl_datapath.sv =====
// ----------------------------------------------------------------------------
// dcsl_datapath
// Per-core cycle totals, tick conversion and half-slot split.
// ----------------------------------------------------------------------------
`default_nettype none
module dcsl_datapath import dcsl_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cmd            i_cmd,
    input  wire t_cfg            i_cfg,
    input  wire logic [IN_W-1:0] i_data,
    input  wire logic            i_out_take,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    output logic [31:0]          o_count,
    output logic [15:0]          o_phase
);

    logic [2*CORE_W-1:0] r_in;
    logic [63:0] r_total [2];
    logic [31:0] r_last  [2];
    logic        r_valid [2];
    logic [73:0] r_skp;
    logic [29:0] r_cpu_hz;
    logic [63:0] r_cyc;
    logic [58:0] r_plo;
    logic [58:0] r_phi;
    logic [56:0] r_pfr;
    logic [63:0] r_tw;
    logic [63:0] r_best;
    logic        r_out_valid;
    logic [31:0] r_count;
    logic [15:0] r_phase;

    logic [CORE_W-1:0] w_core;
    logic              w_present;
    logic [9:0]        w_mhz;
    logic [31:0]       w_live;
    logic [63:0]       w_pub;
    logic [63:0]       w_skip;
    logic              w_active;
    logic [31:0]       w_delta;
    logic [63:0]       w_acc;
    logic [63:0]       w_upd;
    logic [64:0]       w_comb;
    logic [63:0]       w_tw;
    logic [63:0]       w_tc;
    logic              w_div_start;
    logic [63:0]       w_dividend;
    logic [29:0]       w_divisor;
    logic              w_div_busy;
    logic [63:0]       w_quot;
    logic [29:0]       w_rem;

    assign w_core    = i_cmd.core ? r_in[2*CORE_W-1:CORE_W] : r_in[CORE_W-1:0];
    assign w_present = w_core[0];
    assign w_mhz     = w_core[10:1];
    assign w_live    = w_core[42:11];
    assign w_pub     = w_core[106:43];
    assign w_skip    = w_core[170:107];
    assign w_active  = w_present && (w_mhz != 10'd0);

    always_comb begin
        w_delta = w_live - r_last[i_cmd.core];
        w_acc   = (w_delta < DELTA_LIM) ?
                  sat_add(r_total[i_cmd.core], {32'd0, w_delta}) : r_total[i_cmd.core];
        if (!r_valid[i_cmd.core]) begin
            w_upd = w_pub;
        end else begin
            w_upd = (w_pub > w_acc) ? w_pub : w_acc;
        end
        w_comb = {1'b0, r_phi[31:0], 32'd0} + {6'd0, r_plo};
        w_tw   = ((r_phi[58:32] != 27'd0) || w_comb[64]) ? U64_MAX : w_comb[63:0];
        w_tc   = (w_active && (i_cfg.tick_rate != 27'd0)) ? sat_add(r_tw, w_quot) : 64'd0;
    end

    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = r_cyc;
        w_divisor   = r_cpu_hz;
        case (i_cmd.op)
            OP_DIV_CYC: begin
                w_div_start = 1'b1;
            end
            OP_DIV_FRAC: begin
                w_div_start = 1'b1;
                w_dividend  = {7'd0, r_pfr};
            end
            OP_DIV_SLOT: begin
                w_div_start = 1'b1;
                w_dividend  = r_best;
                w_divisor   = {14'd0, i_cfg.half_slot};
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    dcsl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total[0]  <= '0;
            r_total[1]  <= '0;
            r_last[0]   <= '0;
            r_last[1]   <= '0;
            r_valid[0]  <= 1'b0;
            r_valid[1]  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_take && (i_cmd.op != OP_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_in <= i_data[2*CORE_W-1:0];
                end
                OP_TOTAL: begin
                    if (w_active) begin
                        r_total[i_cmd.core] <= w_upd;
                        r_last[i_cmd.core]  <= w_live;
                        r_valid[i_cmd.core] <= 1'b1;
                    end
                    r_skp    <= {10'd0, w_skip} * {64'd0, w_mhz};
                    r_cpu_hz <= {20'd0, w_mhz} * {10'd0, MHZ_SCALE};
                end
                OP_SUM: begin
                    r_cyc <= (r_skp[73:64] != 10'd0) ? U64_MAX :
                             sat_add(r_total[i_cmd.core], r_skp[63:0]);
                end
                OP_MUL_LO: begin
                    r_plo <= {27'd0, w_quot[31:0]} * {32'd0, i_cfg.tick_rate};
                end
                OP_MUL_HI: begin
                    r_phi <= {27'd0, w_quot[63:32]} * {32'd0, i_cfg.tick_rate};
                    r_pfr <= {27'd0, w_rem} * {30'd0, i_cfg.tick_rate};
                end
                OP_DIV_FRAC: begin
                    r_tw <= w_tw;
                end
                OP_CORE_END: begin
                    if (!i_cmd.core || (w_tc > r_best)) begin
                        r_best <= w_tc;
                    end
                end
                OP_OUT: begin
                    r_out_valid <= 1'b1;
                    if (i_cfg.half_slot == 16'd0) begin
                        r_count <= '0;
                        r_phase <= '0;
                    end else begin
                        r_count <= w_quot[31:0] & i_cfg.mask;
                        r_phase <= i_cfg.half_slot - 16'd1 - w_rem[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.out_valid = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_count         = r_count;
    assign o_phase         = r_phase;

endmodule
`default_nettype wire

// ===== sv/dcsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcsl_ctrl
// Sequencer: walks both cores through total update, divides and multiplies.
// ----------------------------------------------------------------------------
`default_nettype none
module dcsl_ctrl import dcsl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_take,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_TOTAL, S_SUM, S_DCYC, S_WCYC, S_MLO, S_MHI,
        S_DFRAC, S_WFRAC, S_CEND, S_DSLOT, S_WSLOT, S_OUT
    } t_state;

    t_state r_state;
    logic   r_core;
    logic   w_room;

    assign w_room = !i_sts.out_valid || i_out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_core  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_core  <= 1'b0;
                        r_state <= S_TOTAL;
                    end
                end
                S_TOTAL: r_state <= S_SUM;
                S_SUM:   r_state <= S_DCYC;
                S_DCYC:  r_state <= S_WCYC;
                S_WCYC: begin
                    if (!i_sts.div_busy) begin
                        r_state <= S_MLO;
                    end
                end
                S_MLO:   r_state <= S_MHI;
                S_MHI:   r_state <= S_DFRAC;
                S_DFRAC: r_state <= S_WFRAC;
                S_WFRAC: begin
                    if (!i_sts.div_busy) begin
                        r_state <= S_CEND;
                    end
                end
                S_CEND: begin
                    if (!r_core) begin
                        r_core  <= 1'b1;
                        r_state <= S_TOTAL;
                    end else begin
                        r_state <= S_DSLOT;
                    end
                end
                S_DSLOT: r_state <= S_WSLOT;
                S_WSLOT: begin
                    if (!i_sts.div_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_room) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.core = r_core;
        case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_IDLE;
            S_TOTAL: o_cmd.op = OP_TOTAL;
            S_SUM:   o_cmd.op = OP_SUM;
            S_DCYC:  o_cmd.op = OP_DIV_CYC;
            S_MLO:   o_cmd.op = OP_MUL_LO;
            S_MHI:   o_cmd.op = OP_MUL_HI;
            S_DFRAC: o_cmd.op = OP_DIV_FRAC;
            S_CEND:  o_cmd.op = OP_CORE_END;
            S_DSLOT: o_cmd.op = OP_DIV_SLOT;
            S_OUT:   o_cmd.op = w_room ? OP_OUT : OP_IDLE;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

// ===== sv/dual_core_cycle_to_slot_time_latch_top.sv =====
// ----------------------------------------------------------------------------
// dual_core_cycle_to_slot_time_latch_top
// Sequencing: each capture runs five divides on the one shared divider
// (two per core, one for the slot), one after another.
// Input: a new capture is taken only once the previous one is finished; it
// is taken while the previous result waits on the output.
// Reset: synchronous active low; clears core totals and loaded flags and
// restores the registers to tick rate 1 MHz, half slot 1, mask all ones.
// ----------------------------------------------------------------------------
`default_nettype none
module dual_core_cycle_to_slot_time_latch_top import dcsl_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wr_en,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    // core0 present, mhz, live_count, published_total, skipped_us, then core1 same
    input  wire logic [IN_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    // latched_count, latched_phase
    output logic [OUT_W-1:0]     m_axis_tdata
);

    t_cfg        r_cfg;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [31:0] w_count;
    logic [15:0] w_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_rate <= 27'd1000000;
            r_cfg.half_slot <= 16'd1;
            r_cfg.mask      <= 32'hFFFF_FFFF;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_TICK_RATE: r_cfg.tick_rate <= i_cfg_data[26:0];
                REG_HALF_SLOT: r_cfg.half_slot <= i_cfg_data[15:0];
                REG_CNT_MASK:  r_cfg.mask      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dcsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_take (m_axis_tready),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    dcsl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_data      (s_axis_tdata),
        .i_out_take  (m_axis_tready),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_count     (w_count),
        .o_phase     (w_phase)
    );

    assign m_axis_tdata = {w_phase, w_count};

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_sts.div_busy)
        else $error("divider busy while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready held after accept");

    a_out_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_OUT) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the dual-core cycle-to-slot time latch. It drives capture
// items with random idling on both stream sides, models the per-core cycle
// totals and the tick / half-slot split, and checks every result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class slot_latch_scoreboard;
    logic [26:0] tick_rate;
    logic [15:0] half_slot;
    logic [31:0] mask;
    logic [63:0] total [2];
    logic [31:0] last_live [2];
    bit          loaded [2];
    logic [47:0] pending [$];
    int          mismatches;
    int          checked;

    function new();
        reset_state();
        mismatches = 0;
        checked = 0;
    endfunction

    function void reset_state();
        tick_rate = 27'd1000000;
        half_slot = 16'd1;
        mask = 32'hFFFF_FFFF;
        for (int c = 0; c < 2; c++) begin
            total[c] = '0;
            last_live[c] = '0;
            loaded[c] = 0;
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
        if (idx == dcsl_pkg::REG_TICK_RATE) tick_rate = val[26:0];
        else if (idx == dcsl_pkg::REG_HALF_SLOT) half_slot = val[15:0];
        else if (idx == dcsl_pkg::REG_CNT_MASK) mask = val;
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function logic [63:0] core_ticks(int c, logic [170:0] f);
        logic        present;
        logic [9:0]  mhz;
        logic [31:0] live, delta;
        logic [63:0] pub, skip, cyc, hz, whole, frac;
        logic [127:0] prod;
        present = f[0];
        mhz = f[10:1];
        live = f[42:11];
        pub = f[106:43];
        skip = f[170:107];
        if (!present || mhz == 0) return 0;
        if (!loaded[c]) begin
            total[c] = pub;
            loaded[c] = 1;
        end else begin
            delta = live - last_live[c];
            if (delta < 32'h7FFF_FFFF) total[c] = add_sat(total[c], {32'd0, delta});
            if (pub > total[c]) total[c] = pub;
        end
        last_live[c] = live;
        prod = skip * mhz;
        cyc = add_sat(total[c], prod[127:64] != 0 ? '1 : prod[63:0]);
        if (tick_rate == 0) return 0;
        hz = mhz * 64'd1000000;
        whole = cyc / hz;
        prod = whole * tick_rate;
        frac = ((cyc % hz) * tick_rate) / hz;
        return add_sat(prod[127:64] != 0 ? '1 : prod[63:0], frac);
    endfunction

    function void note_capture(logic [343:0] d);
        logic [63:0] t0, t1, t, q, r;
        logic [31:0] cnt;
        logic [15:0] ph;
        t0 = core_ticks(0, d[170:0]);
        t1 = core_ticks(1, d[341:171]);
        t = t0 > t1 ? t0 : t1;
        if (half_slot == 0) begin
            cnt = 0;
            ph = 0;
        end else begin
            q = t / half_slot;
            r = t % half_slot;
            cnt = q[31:0] & mask;
            ph = half_slot - 16'd1 - r[15:0];
        end
        pending.push_back({ph, cnt});
    endfunction

    function void check_result(logic [47:0] got);
        logic [47:0] exp;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", got);
            return;
        end
        exp = pending.pop_front();
        if (exp[31:0] !== got[31:0] || exp[47:32] !== got[47:32]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: count exp %h got %h, phase exp %h got %h",
                         exp[31:0], got[31:0], exp[47:32], got[47:32]);
        end
    endfunction
endclass

module tb_top;
    import dcsl_pkg::*;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_wr_en = 0;
    logic [1:0]        i_cfg_index = '0;
    logic [31:0]       i_cfg_data = '0;
    logic              s_axis_tvalid = 0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 0;
    logic [OUT_W-1:0]  m_axis_tdata;

    slot_latch_scoreboard sb;
    bit   calm = 0;
    bit   timed_out = 0;
    int   idle_cycles = 0;
    int   sent = 0;
    logic [63:0] live_seed [2];

    localparam int WATCHDOG = 20000;

    always #1 i_clk = ~i_clk;

    dual_core_cycle_to_slot_time_latch_top uut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("dual_core_cycle_to_slot_time_latch_top verification failed");
            $finish;
        end
    end

    // receiver stalls
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 0;
                n = $urandom_range(1, 6);
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge i_clk);
        end
    end

    task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_wr_en <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_capture(logic [IN_W-1:0] d);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            n = $urandom_range(1, 6);
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_capture(d);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [170:0] pack_core(logic p, logic [9:0] m, logic [31:0] l,
                                               logic [63:0] pub, logic [63:0] sk);
        return {sk, pub, l, m, p};
    endfunction

    // mostly realistic snapshots: small live deltas, modest totals and skips
    function automatic logic [170:0] rand_core(int c);
        logic [63:0] pub, sk;
        logic [9:0]  m;
        int          k;
        k = $urandom_range(0, 19);
        m = ($urandom_range(0, 15) == 0) ? 10'd0 : 10'($urandom_range(1, 1023));
        live_seed[c] = live_seed[c] + (k == 0 ? 64'($urandom()) : 64'($urandom_range(0, 5000000)));
        pub = (k == 1) ? rand64() : (k < 6 ? 64'($urandom_range(0, 1000000)) << 12 : 64'd0);
        sk = (k == 2) ? rand64() : (k < 8 ? 64'($urandom_range(0, 100000)) : 64'd0);
        return pack_core($urandom_range(0, 9) != 0, m, live_seed[c][31:0], pub, sk);
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_capture({2'b00, rand_core(1), rand_core(0)});
    endtask

    initial begin
        logic [63:0] ones;
        sb = new();
        ones = '1;
        live_seed[0] = 0;
        live_seed[1] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: load, small/large deltas, floor by published, saturation
        send_capture({2'b00, pack_core(1, 10'd100, 32'd5, 64'd1000, 64'd0),
                      pack_core(0, 10'd1, 32'd0, 64'd0, 64'd0)});
        send_capture({2'b00, pack_core(1, 10'd100, 32'd1005, 64'd5, 64'd3),
                      pack_core(1, 10'd1023, 32'hFFFF_FFFF, 64'd77, 64'd2)});
        send_capture({2'b00, pack_core(1, 10'd100, 32'h8000_0010, 64'd0, 64'd0),
                      pack_core(1, 10'd1023, 32'd3, 64'd1_000_000_000, 64'd0)});
        send_capture({2'b00, pack_core(1, 10'd0, 32'd9, ones, ones),
                      pack_core(1, 10'd1, 32'h7FFF_FFFF, 64'd0, 64'd1)});
        send_capture({2'b00, pack_core(1, 10'd1023, 32'h7FFF_FFFE, ones, ones),
                      pack_core(1, 10'd512, 32'h7FFF_FFFE, ones - 2, 64'd10)});
        send_capture({2'b11, pack_core(1, 10'd1023, 32'hFFFF_FFFF, ones, ones),
                      pack_core(1, 10'd1023, 32'hFFFF_FFFF, ones, ones)});
        drain();

        write_cfg(REG_TICK_RATE, 32'd100000000);
        write_cfg(REG_HALF_SLOT, 32'd65535);
        write_cfg(REG_CNT_MASK, 32'h0000_0FFF);
        send_capture({2'b00, pack_core(1, 10'd1, 32'd10, 64'd123456789, 64'd0),
                      pack_core(1, 10'd7, 32'd20, 64'd99, 64'd55)});
        send_capture({2'b00, pack_core(0, 10'd1, 32'd10, 64'd0, 64'd0),
                      pack_core(1, 10'd7, 32'd25, 64'd99, ones)});
        drain();
        write_cfg(REG_TICK_RATE, 32'd0);
        send_capture({2'b00, pack_core(1, 10'd3, 32'd1, 64'd50, 64'd50),
                      pack_core(1, 10'd3, 32'd1, 64'd50, 64'd50)});
        drain();
        write_cfg(REG_TICK_RATE, 32'd1);
        write_cfg(REG_HALF_SLOT, 32'd0);
        send_capture({2'b00, pack_core(1, 10'd3, 32'd1, ones, 64'd0),
                      pack_core(1, 10'd3, 32'd1, 64'd50, 64'd50)});
        drain();

        // random phases through several register settings
        write_cfg(REG_TICK_RATE, 32'd1000000);
        write_cfg(REG_HALF_SLOT, 32'd1);
        write_cfg(REG_CNT_MASK, 32'hFFFF_FFFF);
        random_phase(300);
        drain();
        write_cfg(REG_TICK_RATE, 32'h07FF_FFFF);
        write_cfg(REG_HALF_SLOT, 32'd625);
        write_cfg(REG_CNT_MASK, 32'h00FF_00FF);
        random_phase(300);
        drain();
        write_cfg(REG_TICK_RATE, 32'($urandom_range(1, 100000000)));
        write_cfg(REG_HALF_SLOT, 32'($urandom_range(1, 65535)));
        write_cfg(REG_CNT_MASK, $urandom());
        random_phase(300);
        drain();
        write_cfg(REG_TICK_RATE, 32'd32768);
        write_cfg(REG_HALF_SLOT, 32'd0);
        write_cfg(REG_CNT_MASK, 32'd0);
        random_phase(100);
        drain();
        write_cfg(REG_TICK_RATE, 32'd1000000);
        write_cfg(REG_HALF_SLOT, 32'd312);
        write_cfg(REG_CNT_MASK, 32'hFFFF_FFFF);
        random_phase(200);
        calm = 1;
        random_phase(130);
        drain();

        $display("captures sent %0d, results checked %0d, mismatches %0d", sent,
                 sb.checked, sb.mismatches);
        $display("covered register extremes, zero rate and half slot, saturation, wraps");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("dual_core_cycle_to_slot_time_latch_top verification clean");
        else
            $display("dual_core_cycle_to_slot_time_latch_top verification failed");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
sv/dcsl_pkg.sv
sv/dcsl_div.sv
sv/dcsl_datapath.sv
sv/dcsl_ctrl.sv
sv/dual_core_cycle_to_slot_time_latch_top.sv
test/tb_top.sv
